@@ design/mtu_pkg.sv @@
// Package for the MIDI byte stream to USB-MIDI event packer.
// Holds the parse phase type, code index and status constants, the packet
// struct and the status lookup table. No dependencies.
`default_nettype none

package mtu_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_IGNORE = 5'b00001,
    PH_STATUS = 5'b00010,
    PH_SYSEX  = 5'b00100,
    PH_WAIT1  = 5'b01000,
    PH_WAIT2  = 5'b10000
  } phase_t;

  // USB-MIDI code index numbers
  localparam logic [3:0] CIN_SYSCOM2    = 4'h2;
  localparam logic [3:0] CIN_SYSCOM3    = 4'h3;
  localparam logic [3:0] CIN_SYSEX      = 4'h4;
  localparam logic [3:0] CIN_SINGLE     = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
  localparam logic [3:0] CIN_REALTIME   = 4'hF;
  localparam logic [3:0] CIN_NONE       = 4'h0;

  // MIDI status bytes of interest
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_REALTIME    = 8'hF8;
  localparam logic [3:0] HI_VOICE_LO    = 4'h8;
  localparam logic [3:0] HI_PROG_CHG    = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES   = 4'hD;
  localparam logic [3:0] HI_VOICE_HI    = 4'hE;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;

  localparam logic [7:0] UNUSED_BYTE = 8'h00;
  localparam logic [1:0] SYSEX_CHUNK = 2'd3;

  // One USB-MIDI event packet
  typedef struct packed {
    logic [3:0] cable;
    logic [3:0] code_index;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } packet_t;

  // Parser result for one processed byte
  typedef struct packed {
    logic    emit;
    packet_t pkt;
  } result_t;

  // Status table entry
  typedef struct packed {
    logic       known;
    logic       single;
    logic [3:0] code;
    phase_t     next;
  } status_info_t;

  // Status lookup: voice statuses, system common with data, single byte
  function automatic status_info_t lookup(input logic [7:0] s);
    status_info_t r;
    r.known  = 1'b0;
    r.single = 1'b0;
    r.code   = CIN_NONE;
    r.next   = PH_IGNORE;
    if (s[7] && s[7:4] != HI_SYSTEM) begin
      r.known = 1'b1;
      r.code  = s[7:4];
      r.next  = (s[7:4] == HI_PROG_CHG || s[7:4] == HI_CHAN_PRES) ? PH_WAIT1 : PH_WAIT2;
    end else begin
      unique case (s)
        ST_MTC_QFRAME, ST_SONG_SEL: begin
          r.known = 1'b1;
          r.code  = CIN_SYSCOM2;
          r.next  = PH_WAIT1;
        end
        ST_SONG_POS: begin
          r.known = 1'b1;
          r.code  = CIN_SYSCOM3;
          r.next  = PH_WAIT2;
        end
        ST_TUNE_REQ: begin
          r.known  = 1'b1;
          r.single = 1'b1;
          r.code   = CIN_SINGLE;
          r.next   = PH_STATUS;
        end
        default: begin
          r.known = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/mtu_in_stage.sv @@
// Input register of the packer: holds one accepted MIDI byte until the
// parser consumes it. Depends on nothing but its ports.
`default_nettype none

module mtu_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] midi_byte,
  input  wire logic       advance,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  logic held_valid_next;

  // Free when empty or when the held byte moves on this cycle
  assign byte_ready = !held_valid || advance;

  always_comb begin
    held_valid_next = held_valid;
    if (byte_valid && byte_ready) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      held_byte <= midi_byte;
    end
  end

endmodule

`default_nettype wire

@@ design/mtu_parser.sv @@
// MIDI parser: phase, running status and pending message registers, and
// the single-pass decode of one byte. Uses mtu_pkg.
`default_nettype none

module mtu_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [7:0]    midi_byte,
  input  wire logic [3:0]    cable,
  output mtu_pkg::result_t   result
);

  mtu_pkg::phase_t phase, phase_next;
  logic [7:0] rstatus, rstatus_next;
  logic [3:0] pcode, pcode_next;
  logic [7:0] pbytes [3];
  logic [7:0] pbytes_next [3];
  logic [1:0] fill, fill_next;

  mtu_pkg::status_info_t info;
  mtu_pkg::status_info_t run_info;
  logic [1:0] sx_idx;
  logic [1:0] wt_idx;
  logic       sysex_end;

  assign info     = mtu_pkg::lookup(midi_byte);
  assign run_info = mtu_pkg::lookup(rstatus);

  // Slot of the next sysex byte and of the next message data byte
  assign sx_idx    = (fill == mtu_pkg::SYSEX_CHUNK) ? 2'd0 : fill;
  assign wt_idx    = (fill == 2'd1 || fill == 2'd2) ? fill : 2'd1;
  assign sysex_end = (phase == mtu_pkg::PH_SYSEX) && (midi_byte == mtu_pkg::ST_SYSEX_END);

  // Decode of one byte
  always_comb begin
    phase_next     = phase;
    rstatus_next   = rstatus;
    pcode_next     = pcode;
    pbytes_next    = pbytes;
    fill_next      = fill;
    result.emit    = 1'b0;
    result.pkt     = '{cable: cable, code_index: mtu_pkg::CIN_NONE,
                       b0: mtu_pkg::UNUSED_BYTE, b1: mtu_pkg::UNUSED_BYTE,
                       b2: mtu_pkg::UNUSED_BYTE};

    if (midi_byte >= mtu_pkg::ST_REALTIME) begin
      // Real-time passes through, state untouched
      result.emit           = 1'b1;
      result.pkt.code_index = mtu_pkg::CIN_REALTIME;
      result.pkt.b0         = midi_byte;
    end else if (midi_byte[7] && !sysex_end) begin
      // New status: any message in progress is dropped
      if (midi_byte == mtu_pkg::ST_SYSEX_START) begin
        rstatus_next   = 8'h00;
        pcode_next     = mtu_pkg::CIN_SYSEX;
        pbytes_next[0] = midi_byte;
        fill_next      = 2'd1;
        phase_next     = mtu_pkg::PH_SYSEX;
      end else begin
        rstatus_next = midi_byte[6:4] != 3'b111 ? midi_byte : 8'h00;
        if (!info.known) begin
          phase_next = mtu_pkg::PH_IGNORE;
        end else if (info.single) begin
          phase_next            = mtu_pkg::PH_STATUS;
          result.emit           = 1'b1;
          result.pkt.code_index = info.code;
          result.pkt.b0         = midi_byte;
        end else begin
          pcode_next     = info.code;
          pbytes_next[0] = midi_byte;
          pbytes_next[1] = mtu_pkg::UNUSED_BYTE;
          pbytes_next[2] = mtu_pkg::UNUSED_BYTE;
          fill_next      = 2'd1;
          phase_next     = info.next;
        end
      end
    end else begin
      unique case (phase)
        mtu_pkg::PH_IGNORE: begin
          phase_next = mtu_pkg::PH_IGNORE;
        end
        mtu_pkg::PH_STATUS: begin
          // Running status, voice statuses only
          if (rstatus[7]) begin
            pcode_next     = run_info.code;
            pbytes_next[0] = rstatus;
            pbytes_next[1] = midi_byte;
            pbytes_next[2] = mtu_pkg::UNUSED_BYTE;
            fill_next      = 2'd2;
            if (run_info.next == mtu_pkg::PH_WAIT2) begin
              phase_next = mtu_pkg::PH_WAIT1;
            end else begin
              phase_next            = mtu_pkg::PH_STATUS;
              result.emit           = 1'b1;
              result.pkt.code_index = run_info.code;
              result.pkt.b0         = rstatus;
              result.pkt.b1         = midi_byte;
            end
          end
        end
        mtu_pkg::PH_SYSEX: begin
          pbytes_next[sx_idx] = midi_byte;
          if (sysex_end) begin
            phase_next    = mtu_pkg::PH_STATUS;
            fill_next     = 2'd0;
            result.emit   = 1'b1;
            result.pkt.b0 = pbytes_next[0];
            case (sx_idx)
              2'd0: result.pkt.code_index = mtu_pkg::CIN_SINGLE;
              2'd1: begin
                result.pkt.code_index = mtu_pkg::CIN_SYSEX_END2;
                result.pkt.b1         = pbytes_next[1];
              end
              default: begin
                result.pkt.code_index = mtu_pkg::CIN_SYSEX_END3;
                result.pkt.b1         = pbytes_next[1];
                result.pkt.b2         = pbytes_next[2];
              end
            endcase
          end else if (sx_idx + 2'd1 == mtu_pkg::SYSEX_CHUNK) begin
            // Full 3-byte chunk
            fill_next             = 2'd0;
            result.emit           = 1'b1;
            result.pkt.code_index = mtu_pkg::CIN_SYSEX;
            result.pkt.b0         = pbytes_next[0];
            result.pkt.b1         = pbytes_next[1];
            result.pkt.b2         = pbytes_next[2];
          end else begin
            fill_next = sx_idx + 2'd1;
          end
        end
        mtu_pkg::PH_WAIT1, mtu_pkg::PH_WAIT2: begin
          pbytes_next[wt_idx] = midi_byte;
          fill_next           = wt_idx + 2'd1;
          if (phase == mtu_pkg::PH_WAIT2) begin
            phase_next = mtu_pkg::PH_WAIT1;
          end else begin
            phase_next            = mtu_pkg::PH_STATUS;
            result.emit           = 1'b1;
            result.pkt.code_index = pcode;
            result.pkt.b0         = pbytes_next[0];
            result.pkt.b1         = pbytes_next[1];
            result.pkt.b2         = (wt_idx == 2'd2) ? pbytes_next[2] : mtu_pkg::UNUSED_BYTE;
          end
        end
        default: begin
          phase_next = mtu_pkg::PH_IGNORE;
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mtu_pkg::PH_IGNORE;
      rstatus   <= 8'h00;
      pcode     <= mtu_pkg::CIN_NONE;
      pbytes[0] <= mtu_pkg::UNUSED_BYTE;
      pbytes[1] <= mtu_pkg::UNUSED_BYTE;
      pbytes[2] <= mtu_pkg::UNUSED_BYTE;
      fill      <= 2'd0;
    end else if (advance) begin
      phase     <= phase_next;
      rstatus   <= rstatus_next;
      pcode     <= pcode_next;
      pbytes    <= pbytes_next;
      fill      <= fill_next;
    end
  end

endmodule

`default_nettype wire

@@ design/mtu_out_stage.sv @@
// Result register of the packer: holds one packet until the sink takes it.
// Uses mtu_pkg for the packet struct.
`default_nettype none

module mtu_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire mtu_pkg::packet_t load_pkt,
  input  wire logic             packet_ready,
  output logic                  packet_valid,
  output mtu_pkg::packet_t      pkt
);

  logic packet_valid_next;

  always_comb begin
    packet_valid_next = packet_valid;
    if (load) begin
      packet_valid_next = 1'b1;
    end else if (packet_ready) begin
      packet_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
    end else begin
      packet_valid <= packet_valid_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      pkt <= load_pkt;
    end
  end

endmodule

`default_nettype wire

@@ design/midi_to_usb_midi_event_packer_top.sv @@
// Top level of the MIDI byte stream to USB-MIDI event packer.
// Instantiates mtu_in_stage, mtu_parser and mtu_out_stage; uses mtu_pkg.
//
//   channel   handshake                  payload
//   -------   -------------------------  ------------------------------------
//   byte      byte_valid / byte_ready    midi_byte
//   packet    packet_valid / packet_ready cable, code_index, packet_byte_0..2
//   cfg       cfg_valid / cfg_ready      cable_number
//
// One byte per cycle sustained while the sink keeps taking packets; the byte
// beat loads the input register, and the decoded packet is then loaded into
// the result register, which raises packet_valid.
// The byte in the input register is decoded when the result register is
// empty or being taken; a stalled sink holds the input side after one beat.
// Synchronous reset clears handshake state and the parser (ignoring until a
// status byte, no running status, cable number 0). cfg_ready is always high.
`default_nettype none

module midi_to_usb_midi_event_packer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] midi_byte,
  output logic            packet_valid,
  input  wire logic       packet_ready,
  output logic [3:0]      cable,
  output logic [3:0]      code_index,
  output logic [7:0]      packet_byte_0,
  output logic [7:0]      packet_byte_1,
  output logic [7:0]      packet_byte_2,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cable_number
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              advance;
  logic [3:0]        cable_cfg;
  mtu_pkg::result_t  result;
  mtu_pkg::packet_t  out_pkt;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cable_cfg <= 4'h0;
    end else if (cfg_valid && cfg_ready) begin
      cable_cfg <= cable_number;
    end
  end

  // Decode the held byte when the result register can take a packet
  assign advance = held_valid && (!packet_valid || packet_ready);

  mtu_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .midi_byte  (midi_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mtu_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .midi_byte (held_byte),
    .cable     (cable_cfg),
    .result    (result)
  );

  mtu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && result.emit),
    .load_pkt     (result.pkt),
    .packet_ready (packet_ready),
    .packet_valid (packet_valid),
    .pkt          (out_pkt)
  );

  assign cable         = out_pkt.cable;
  assign code_index    = out_pkt.code_index;
  assign packet_byte_0 = out_pkt.b0;
  assign packet_byte_1 = out_pkt.b1;
  assign packet_byte_2 = out_pkt.b2;

endmodule

`default_nettype wire

@@ design/mtu_checker.sv @@
// Port-level checks for the packer, bound to the top level.
// Depends on the top level's ports and on mtu_pkg for code constants.
`default_nettype none

module mtu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       byte_valid,
  input wire logic       byte_ready,
  input wire logic [7:0] midi_byte,
  input wire logic       packet_valid,
  input wire logic       packet_ready,
  input wire logic [3:0] cable,
  input wire logic [3:0] code_index,
  input wire logic [7:0] packet_byte_0,
  input wire logic [7:0] packet_byte_1,
  input wire logic [7:0] packet_byte_2
);

  // A stalled packet beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    packet_valid && !packet_ready |=> packet_valid && $stable(cable) && $stable(code_index)
      && $stable(packet_byte_0) && $stable(packet_byte_1) && $stable(packet_byte_2))
    else $error("packet payload changed while stalled");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !packet_valid)
    else $error("packet valid after reset");

  // A real-time byte passes through the input and result registers unchanged when the sink is taking beats
  a_realtime: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_ready && midi_byte >= mtu_pkg::ST_REALTIME) ##1 packet_ready |=>
      packet_valid && code_index == mtu_pkg::CIN_REALTIME
      && packet_byte_0 == $past(midi_byte, 2))
    else $error("real-time byte not passed through");

  // Short events leave the third byte zero
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    packet_valid && (code_index == mtu_pkg::CIN_REALTIME || code_index == mtu_pkg::CIN_SINGLE
      || code_index == mtu_pkg::CIN_SYSCOM2 || code_index == mtu_pkg::CIN_SYSEX_END2
      || code_index == mtu_pkg::HI_PROG_CHG || code_index == mtu_pkg::HI_CHAN_PRES)
      |-> packet_byte_2 == mtu_pkg::UNUSED_BYTE)
    else $error("unused third byte is not zero");

  // Voice code index matches the status nibble
  a_voice_code: assert property (@(posedge clk) disable iff (rst)
    packet_valid && code_index >= mtu_pkg::HI_VOICE_LO && code_index <= mtu_pkg::HI_VOICE_HI
      |-> packet_byte_0[7:4] == code_index)
    else $error("voice code index does not match status");

endmodule

bind midi_to_usb_midi_event_packer_top mtu_checker u_mtu_checker (.*);

`default_nettype wire

@@ sim/tb_midi_to_usb_midi_event_packer_top.sv @@
// Self-checking testbench for midi_to_usb_midi_event_packer_top: byte and packet
// channels under random stalls, checked packet by packet against a local parser model.
// Depends on mtu_pkg and the RTL of the packer; nothing else.

module tb_midi_to_usb_midi_event_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 5;
  localparam int BYTES_PER_PHASE = 265;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] midi_byte = 8'h00;
  logic       packet_valid;
  logic       packet_ready = 1'b0;
  logic [3:0] cable;
  logic [3:0] code_index;
  logic [7:0] packet_byte_0;
  logic [7:0] packet_byte_1;
  logic [7:0] packet_byte_2;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cable_number = 4'h0;

  midi_to_usb_midi_event_packer_top dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .midi_byte    (midi_byte),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .cable        (cable),
    .code_index   (code_index),
    .packet_byte_0(packet_byte_0),
    .packet_byte_1(packet_byte_1),
    .packet_byte_2(packet_byte_2),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cable_number (cable_number)
  );

  always #1 clk = ~clk;

  // Stimulus bytes waiting for the driver, and packets the parser model predicts
  logic [7:0]       byte_stream[$];
  mtu_pkg::packet_t predicted_pkts[$];
  int               idle_pct = 26;
  int               fails = 0;
  int               stall_cycles = 0;

  // Parser model state
  mtu_pkg::phase_t m_phase;
  logic [7:0]      last_voice;
  logic [3:0]      msg_code;
  logic [7:0]      msg_bytes[3];
  logic [1:0]      msg_fill;
  logic [3:0]      cable_reg;

  function automatic mtu_pkg::packet_t form_packet(input logic [3:0] code,
                                                   input logic [7:0] b0,
                                                   input logic [7:0] b1,
                                                   input logic [7:0] b2);
    mtu_pkg::packet_t p;
    p.cable      = cable_reg;
    p.code_index = code;
    p.b0         = b0;
    p.b1         = b1;
    p.b2         = b2;
    return p;
  endfunction

  // Status decode: code index and the phase that follows; 0 for unknown statuses
  function automatic bit classify_status(input logic [7:0] s, output logic [3:0] code,
                                         output mtu_pkg::phase_t nxt);
    code = mtu_pkg::CIN_NONE;
    nxt  = mtu_pkg::PH_IGNORE;
    if (s[7] && s < mtu_pkg::ST_SYSEX_START) begin
      code = s[7:4];
      nxt  = (s[7:4] == mtu_pkg::HI_PROG_CHG || s[7:4] == mtu_pkg::HI_CHAN_PRES) ?
             mtu_pkg::PH_WAIT1 : mtu_pkg::PH_WAIT2;
      return 1'b1;
    end
    if (s == mtu_pkg::ST_MTC_QFRAME || s == mtu_pkg::ST_SONG_SEL) begin
      code = mtu_pkg::CIN_SYSCOM2;
      nxt  = mtu_pkg::PH_WAIT1;
      return 1'b1;
    end
    if (s == mtu_pkg::ST_SONG_POS) begin
      code = mtu_pkg::CIN_SYSCOM3;
      nxt  = mtu_pkg::PH_WAIT2;
      return 1'b1;
    end
    if (s == mtu_pkg::ST_TUNE_REQ) begin
      code = mtu_pkg::CIN_SINGLE;
      nxt  = mtu_pkg::PH_STATUS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void open_message(input logic [7:0] s, input logic [3:0] code,
                                       input mtu_pkg::phase_t nxt);
    msg_code     = code;
    msg_bytes[0] = s;
    msg_bytes[1] = mtu_pkg::UNUSED_BYTE;
    msg_bytes[2] = mtu_pkg::UNUSED_BYTE;
    msg_fill     = 2'd1;
    m_phase      = nxt;
  endfunction

  // Advance the parser model by one byte; returns 1 when a packet results
  function automatic bit pack_midi_byte(input logic [7:0] b, output mtu_pkg::packet_t pkt);
    bit              is_st;
    logic [1:0]      idx;
    logic [3:0]      code;
    mtu_pkg::phase_t nxt;
    int              pass;
    is_st = b[7];
    pkt   = '0;
    if (b >= mtu_pkg::ST_REALTIME) begin
      pkt = form_packet(mtu_pkg::CIN_REALTIME, b, mtu_pkg::UNUSED_BYTE, mtu_pkg::UNUSED_BYTE);
      return 1'b1;
    end
    for (pass = 0; pass < 3; pass++) begin
      idx = msg_fill;
      case (m_phase)
        mtu_pkg::PH_STATUS: begin
          if (b == mtu_pkg::ST_SYSEX_START) begin
            last_voice   = 8'h00;
            msg_code     = mtu_pkg::CIN_SYSEX;
            msg_bytes[0] = b;
            msg_fill     = 2'd1;
            m_phase      = mtu_pkg::PH_SYSEX;
            return 1'b0;
          end
          if (is_st) begin
            last_voice = (b < mtu_pkg::ST_SYSEX_START) ? b : 8'h00;
            if (!classify_status(b, code, nxt)) begin
              m_phase = mtu_pkg::PH_IGNORE;
              return 1'b0;
            end
            if (nxt == mtu_pkg::PH_STATUS) begin
              pkt = form_packet(code, b, mtu_pkg::UNUSED_BYTE, mtu_pkg::UNUSED_BYTE);
              return 1'b1;
            end
            open_message(b, code, nxt);
            return 1'b0;
          end
          // data byte: running status only after a voice status
          if (!last_voice[7] || last_voice >= mtu_pkg::ST_SYSEX_START) return 1'b0;
          void'(classify_status(last_voice, code, nxt));
          open_message(last_voice, code, nxt);
          continue;
        end
        mtu_pkg::PH_SYSEX: begin
          if (is_st && b != mtu_pkg::ST_SYSEX_END) begin
            m_phase = mtu_pkg::PH_STATUS;
            continue;
          end
          if (idx >= mtu_pkg::SYSEX_CHUNK) idx = 2'd0;
          msg_bytes[idx] = b;
          if (b == mtu_pkg::ST_SYSEX_END) begin
            m_phase  = mtu_pkg::PH_STATUS;
            msg_fill = 2'd0;
            if (idx == 2'd0)
              pkt = form_packet(mtu_pkg::CIN_SINGLE, msg_bytes[0], mtu_pkg::UNUSED_BYTE,
                                mtu_pkg::UNUSED_BYTE);
            else if (idx == 2'd1)
              pkt = form_packet(mtu_pkg::CIN_SYSEX_END2, msg_bytes[0], msg_bytes[1],
                                mtu_pkg::UNUSED_BYTE);
            else
              pkt = form_packet(mtu_pkg::CIN_SYSEX_END3, msg_bytes[0], msg_bytes[1],
                                msg_bytes[2]);
            return 1'b1;
          end
          idx = idx + 2'd1;
          if (idx >= mtu_pkg::SYSEX_CHUNK) begin
            msg_fill = 2'd0;
            pkt = form_packet(mtu_pkg::CIN_SYSEX, msg_bytes[0], msg_bytes[1], msg_bytes[2]);
            return 1'b1;
          end
          msg_fill = idx;
          return 1'b0;
        end
        mtu_pkg::PH_WAIT1, mtu_pkg::PH_WAIT2: begin
          if (is_st) begin
            m_phase = mtu_pkg::PH_STATUS;
            continue;
          end
          if (idx < 2'd1 || idx > 2'd2) idx = 2'd1;
          msg_bytes[idx] = b;
          idx = idx + 2'd1;
          msg_fill = idx;
          if (m_phase == mtu_pkg::PH_WAIT2) begin
            m_phase = mtu_pkg::PH_WAIT1;
            return 1'b0;
          end
          m_phase = mtu_pkg::PH_STATUS;
          pkt = form_packet(msg_code, msg_bytes[0], msg_bytes[1],
                            (idx == 2'd3) ? msg_bytes[2] : mtu_pkg::UNUSED_BYTE);
          return 1'b1;
        end
        default: begin
          if (!is_st) begin
            m_phase = mtu_pkg::PH_IGNORE;
            return 1'b0;
          end
          m_phase = mtu_pkg::PH_STATUS;
          continue;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  // Byte driver: predicts on each accepted beat, then offers the next byte or idles
  always @(posedge clk) begin : byte_driver
    mtu_pkg::packet_t p;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        if (pack_midi_byte(midi_byte, p)) predicted_pkts.push_back(p);
      end
      if (!byte_valid || byte_ready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= idle_pct) begin
          byte_valid <= 1'b1;
          midi_byte  <= byte_stream.pop_front();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Packet monitor: compares each accepted beat with the oldest prediction
  always @(posedge clk) begin : packet_monitor
    mtu_pkg::packet_t want;
    if (rst) begin
      packet_ready <= 1'b0;
    end else begin
      if (packet_valid && packet_ready) begin
        if (predicted_pkts.size() == 0) begin
          $error("packet with none predicted: cin 0x%0h bytes %h %h %h",
                 code_index, packet_byte_0, packet_byte_1, packet_byte_2);
          fails++;
        end else begin
          want = predicted_pkts.pop_front();
          check_field("cable", want.cable, cable);
          check_field("code_index", want.code_index, code_index);
          check_field("packet_byte_0", want.b0, packet_byte_0);
          check_field("packet_byte_1", want.b1, packet_byte_1);
          check_field("packet_byte_2", want.b2, packet_byte_2);
        end
      end
      packet_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (packet_valid && packet_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("midi_to_usb_midi_event_packer_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_data();
    return 8'($urandom_range(127));
  endfunction

  function automatic logic [7:0] rand_voice_status();
    return 8'({mtu_pkg::HI_VOICE_LO, 4'h0} + ($urandom_range(6) << 4) + $urandom_range(15));
  endfunction

  // Queue a byte, now and then preceded by a real-time byte
  function automatic void push_byte(input logic [7:0] b);
    if ($urandom_range(99) < 5)
      byte_stream.push_back(8'(mtu_pkg::ST_REALTIME + $urandom_range(7)));
    byte_stream.push_back(b);
  endfunction

  // Mostly well-formed messages with random content, plus truncation and noise
  function automatic void queue_random_traffic(input int n);
    int         target;
    int         kind;
    int         len;
    int         ndata;
    logic [7:0] st;
    logic [7:0] sc;
    target = byte_stream.size() + n;
    while (byte_stream.size() < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // voice messages, some continued by running status
        st = rand_voice_status();
        ndata = (st[7:4] == mtu_pkg::HI_PROG_CHG || st[7:4] == mtu_pkg::HI_CHAN_PRES) ? 1 : 2;
        push_byte(st);
        repeat ($urandom_range(1, 3)) begin
          len = ($urandom_range(9) == 0) ? ndata - 1 : ndata;
          repeat (len) push_byte(rand_data());
        end
      end else if (kind < 55) begin
        // system common, with an occasional stray data byte after it
        case ($urandom_range(3))
          0: sc = mtu_pkg::ST_MTC_QFRAME;
          1: sc = mtu_pkg::ST_SONG_POS;
          2: sc = mtu_pkg::ST_SONG_SEL;
          default: sc = mtu_pkg::ST_TUNE_REQ;
        endcase
        push_byte(sc);
        ndata = (sc == mtu_pkg::ST_SONG_POS) ? 2 : (sc == mtu_pkg::ST_TUNE_REQ) ? 0 : 1;
        if ($urandom_range(4) == 0) ndata++;
        repeat (ndata) push_byte(rand_data());
      end else if (kind < 75) begin
        // sysex, ended or aborted by another status
        push_byte(mtu_pkg::ST_SYSEX_START);
        repeat ($urandom_range(10)) push_byte(rand_data());
        if ($urandom_range(4) != 0) begin
          push_byte(mtu_pkg::ST_SYSEX_END);
        end else begin
          sc = 8'($urandom_range(8'h80, 8'hF6));
          push_byte(sc);
        end
      end else if (kind < 82) begin
        // unknown status followed by data that must be skipped
        case ($urandom_range(2))
          0: sc = mtu_pkg::ST_UNDEF_F4;
          1: sc = mtu_pkg::ST_UNDEF_F5;
          default: sc = mtu_pkg::ST_SYSEX_END;
        endcase
        push_byte(sc);
        repeat ($urandom_range(3)) push_byte(rand_data());
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3))
          byte_stream.push_back(8'(mtu_pkg::ST_REALTIME + $urandom_range(7)));
      end else begin
        repeat ($urandom_range(1, 4)) byte_stream.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic write_cable(input logic [3:0] v);
    @(posedge clk);
    cfg_valid    <= 1'b1;
    cable_number <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cable_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // Wait until all bytes are taken and all packets seen, then let the pipeline empty
  task automatic wait_drained();
    while (byte_stream.size() != 0 || byte_valid || predicted_pkts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [3:0] cab;
    m_phase    = mtu_pkg::PH_IGNORE;
    last_voice = 8'h00;
    msg_code   = mtu_pkg::CIN_NONE;
    msg_bytes[0] = 8'h00;
    msg_bytes[1] = 8'h00;
    msg_bytes[2] = 8'h00;
    msg_fill   = 2'd0;
    cable_reg  = 4'h0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: real-time and data while ignoring, voice with running status,
    // system common, unknown status, sysex chunking and abort, real-time inside
    // a message, status inside an incomplete message
    byte_stream = '{8'hF8, 8'h45, 8'h90, 8'h7F, 8'h00, 8'h7F, 8'h3C,
                    8'hC5, 8'h7F, 8'hF2, 8'h00, 8'h7F, 8'hB0, 8'h07, 8'hF6,
                    8'hF7, 8'h11, 8'hF0, 8'h01, 8'h02, 8'h03, 8'hF7,
                    8'hF0, 8'h01, 8'h90, 8'hFF, 8'h3C, 8'h40};
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: cab = 4'hF;
        1: cab = 4'h0;
        default: cab = 4'($urandom_range(15));
      endcase
      idle_pct = (ph == 2) ? 0 : 26;
      write_cable(cab);
      queue_random_traffic(BYTES_PER_PHASE);
      wait_drained();
    end

    if (fails == 0) begin
      $display("midi_to_usb_midi_event_packer_top regression: pass");
    end else begin
      $display("midi_to_usb_midi_event_packer_top regression: fail");
    end
    $finish;
  end

endmodule
